// File: hdl/media_stream_deframer_macros.svh
// assertion macros for the media stream deframer
`ifndef MEDIA_STREAM_DEFRAMER_MACROS_SVH
`define MEDIA_STREAM_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
`define MSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("media stream deframer assertion failed");
`define MSD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("media stream deframer forbidden condition");
`else
`define MSD_ASSERT(lbl, prop)
`define MSD_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: hdl/msd_pkg.sv
// types, codes and codec lookup shared by the deframer modules
package msd_pkg;

  localparam logic [31:0] CODE_H264 = 32'h6832_3634;
  localparam logic [31:0] CODE_H265 = 32'h6832_3635;
  localparam logic [31:0] CODE_AV1  = 32'h0061_7631;
  localparam logic [31:0] CODE_OPUS = 32'h6f70_7573;
  localparam logic [31:0] CODE_AAC  = 32'h0061_6163;
  localparam logic [31:0] CODE_FLAC = 32'h666c_6163;
  localparam logic [31:0] CODE_RAW  = 32'h0072_6177;
  localparam logic [31:0] WORD_PAUSE = 32'h0000_0000;
  localparam logic [31:0] WORD_ERROR = 32'h0000_0001;

  localparam logic [3:0] CODEC_LAST_IDX  = 4'd3;
  localparam logic [3:0] SIZE_LAST_IDX   = 4'd7;
  localparam logic [3:0] SIZE_SPLIT_IDX  = 4'd4;
  localparam logic [3:0] HDR_SPLIT_IDX   = 4'd8;
  localparam logic [3:0] HDR_LAST_IDX    = 4'd11;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_OPEN    = 3'd1,
    KIND_HEADER  = 3'd2,
    KIND_PAUSED  = 3'd3,
    KIND_ERROR   = 3'd4,
    KIND_UNSUP   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CODEC_H264 = 3'd0,
    CODEC_H265 = 3'd1,
    CODEC_AV1  = 3'd2,
    CODEC_OPUS = 3'd3,
    CODEC_AAC  = 3'd4,
    CODEC_FLAC = 3'd5,
    CODEC_RAW  = 3'd6,
    CODEC_NONE = 3'd7
  } codec_e;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   data_byte;
    logic         last_of_packet;
    logic [2:0]   codec;
    logic         is_video;
    logic [31:0]  frame_width;
    logic [31:0]  frame_height;
    logic [61:0]  timestamp;
    logic         no_timestamp;
    logic         key_frame;
    logic [31:0]  packet_length;
    logic         merge_config;
  } result_t;

  function automatic codec_e map_codec(input logic [31:0] word, input logic av1_en);
    codec_e c;
    case (word)
      CODE_H264: c = CODEC_H264;
      CODE_H265: c = CODEC_H265;
      CODE_AV1:  c = av1_en ? CODEC_AV1 : CODEC_NONE;
      CODE_OPUS: c = CODEC_OPUS;
      CODE_AAC:  c = CODEC_AAC;
      CODE_FLAC: c = CODEC_FLAC;
      CODE_RAW:  c = CODEC_RAW;
      default:   c = CODEC_NONE;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/msd_in_stage.sv
// input register holding one received byte
module msd_in_stage import msd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       consume_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || consume_i;

  always_comb begin
    valid_d = valid_q;
    if (consume_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

// File: hdl/msd_parser.sv
// stream parser: phase tracking, word assembly and result formation
module msd_parser import msd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       av1_enabled_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  `include "media_stream_deframer_macros.svh"

  typedef enum logic [2:0] {
    PH_CODEC   = 3'd0,
    PH_SIZE    = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_HALT    = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] header_q, header_d;
  logic [31:0] length_q, length_d;
  logic [31:0] left_q, left_d;
  logic [2:0]  codec_q, codec_d;
  logic        video_q, video_d;
  logic [31:0] width_q, width_d;
  logic        av1_q;

  logic [31:0] word;
  logic [31:0] new_len;
  codec_e      mapped;
  logic        mapped_video;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    header_d = header_q;
    length_d = length_q;
    left_d   = left_q;
    codec_d  = codec_q;
    video_d  = video_q;
    width_d  = width_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    word         = {header_q[23:0], byte_i};
    new_len      = {length_q[23:0], byte_i};
    mapped       = map_codec(word, av1_q);
    mapped_video = (mapped == CODEC_H264) || (mapped == CODEC_H265) || (mapped == CODEC_AV1);
    unique case (phase_q)
      PH_CODEC: begin
        header_d = {header_q[55:0], byte_i};
        cnt_d    = cnt_q + 4'd1;
        if (cnt_q == CODEC_LAST_IDX) begin
          cnt_d    = '0;
          header_d = '0;
          res_valid_o = 1'b1;
          if (word == WORD_PAUSE) begin
            res_o.kind = KIND_PAUSED;
          end else if (word == WORD_ERROR) begin
            res_o.kind = KIND_ERROR;
            phase_d    = PH_HALT;
          end else if (mapped == CODEC_NONE) begin
            res_o.kind = KIND_UNSUP;
            phase_d    = PH_HALT;
          end else begin
            codec_d = mapped;
            video_d = mapped_video;
            width_d = '0;
            if (mapped_video) begin
              res_valid_o = 1'b0;
              phase_d     = PH_SIZE;
            end else begin
              phase_d            = PH_HEADER;
              res_o.kind         = KIND_OPEN;
              res_o.codec        = mapped;
              res_o.is_video     = 1'b0;
              res_o.merge_config = 1'b0;
            end
          end
        end
      end
      PH_SIZE: begin
        if (cnt_q < SIZE_SPLIT_IDX) begin
          width_d = {width_q[23:0], byte_i};
        end else begin
          header_d = {header_q[55:0], byte_i};
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == SIZE_LAST_IDX) begin
          cnt_d              = '0;
          header_d           = '0;
          phase_d            = PH_HEADER;
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_OPEN;
          res_o.codec        = codec_q;
          res_o.is_video     = video_q;
          res_o.merge_config = (codec_q <= CODEC_H265);
          res_o.frame_width  = width_q;
          res_o.frame_height = word;
        end
      end
      PH_HEADER: begin
        if (cnt_q < HDR_SPLIT_IDX) begin
          header_d = {header_q[55:0], byte_i};
        end else begin
          length_d = new_len;
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == HDR_LAST_IDX) begin
          cnt_d       = '0;
          header_d    = '0;
          res_valid_o = 1'b1;
          if (new_len == '0) begin
            res_o.kind = KIND_PAUSED;
            phase_d    = PH_CODEC;
          end else begin
            res_o.kind          = KIND_HEADER;
            res_o.codec         = codec_q;
            res_o.is_video      = video_q;
            res_o.merge_config  = (codec_q <= CODEC_H265);
            res_o.no_timestamp  = header_q[63];
            res_o.timestamp     = header_q[63] ? '0 : header_q[61:0];
            res_o.key_frame     = header_q[62];
            res_o.packet_length = new_len;
            left_d   = new_len;
            length_d = '0;
            phase_d  = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid_o          = 1'b1;
        res_o.kind           = KIND_PAYLOAD;
        res_o.data_byte      = byte_i;
        res_o.codec          = codec_q;
        res_o.is_video       = video_q;
        res_o.merge_config   = (codec_q <= CODEC_H265);
        if (left_q <= 32'd1) begin
          res_o.last_of_packet = 1'b1;
          left_d  = '0;
          phase_d = PH_HEADER;
        end else begin
          left_d = left_q - 32'd1;
        end
      end
      PH_HALT: begin
        phase_d = PH_HALT;
      end
      default: begin
        phase_d = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_CODEC;
      cnt_q    <= '0;
      header_q <= '0;
      length_q <= '0;
      left_q   <= '0;
      codec_q  <= '0;
      video_q  <= 1'b0;
      width_q  <= '0;
      av1_q    <= 1'b1;
    end else begin
      if (cfg_valid_i) begin
        av1_q <= av1_enabled_i;
      end
      if (step_i) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        header_q <= header_d;
        length_q <= length_d;
        left_q   <= left_d;
        codec_q  <= codec_d;
        video_q  <= video_d;
        width_q  <= width_d;
      end
    end
  end

  `MSD_ASSERT(a_halt_sticky, (phase_q == PH_HALT) |=> (phase_q == PH_HALT))
  `MSD_ASSERT(a_codec_count, (phase_q == PH_CODEC) |-> (cnt_q < 4'd4))
  `MSD_ASSERT(a_payload_count, (phase_q == PH_PAYLOAD) |-> (cnt_q == 4'd0))
  `MSD_ASSERT(a_last_to_header,
              (step_i && phase_q == PH_PAYLOAD && res_o.last_of_packet) |=>
              (phase_q == PH_HEADER))
  `MSD_ASSERT_NEVER(a_halt_no_result, (phase_q == PH_HALT) && res_valid_o)

endmodule

// File: hdl/msd_out_stage.sv
// result register toward the downstream consumer
module msd_out_stage import msd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: hdl/media_stream_deframer.sv
// top level of the media stream deframer
// a byte that yields a result passes the input register, parser and output register
// throughput: one byte per cycle unless the output register holds a stalled result
// the output register lets a new byte enter while a result waits downstream
// reset: asynchronous active low; parse state cleared, av1 enabled, no result pending
module media_stream_deframer import msd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        av1_enabled_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        last_of_packet_o,
  output logic [2:0]  codec_o,
  output logic        is_video_o,
  output logic [31:0] frame_width_o,
  output logic [31:0] frame_height_o,
  output logic [61:0] timestamp_o,
  output logic        no_timestamp_o,
  output logic        key_frame_o,
  output logic [31:0] packet_length_o,
  output logic        merge_config_o
);

  logic       byte_valid;
  logic [7:0] byte_val;
  logic       consume;
  logic       res_valid;
  result_t    res;
  logic       out_free;
  result_t    out_res;

  assign cfg_ready_o = 1'b1;
  assign consume     = byte_valid && (!res_valid || out_free);

  msd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .consume_i    (consume),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_val)
  );

  msd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .av1_enabled_i (av1_enabled_i),
    .step_i        (consume),
    .byte_i        (byte_val),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  msd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign kind_o           = out_res.kind;
  assign data_byte_o      = out_res.data_byte;
  assign last_of_packet_o = out_res.last_of_packet;
  assign codec_o          = out_res.codec;
  assign is_video_o       = out_res.is_video;
  assign frame_width_o    = out_res.frame_width;
  assign frame_height_o   = out_res.frame_height;
  assign timestamp_o      = out_res.timestamp;
  assign no_timestamp_o   = out_res.no_timestamp;
  assign key_frame_o      = out_res.key_frame;
  assign packet_length_o  = out_res.packet_length;
  assign merge_config_o   = out_res.merge_config;

endmodule
